FILE: rtl/cbts_pkg.sv
package cbts_pkg;

  localparam int unsigned TQ_MAX          = 25;
  localparam int unsigned TQ_MIN          = 5;
  localparam int unsigned BRP_MAX         = 64;
  localparam int unsigned TRIPLE_LIMIT    = 125000;
  localparam int unsigned SP_HIGH         = 700;
  localparam int unsigned SP_LOW          = 600;
  localparam int unsigned PPM_SCALE_LIMIT = 4294;
  localparam int unsigned PPM_UNIT        = 1000000;
  localparam int unsigned PERMILLE        = 1000;
  localparam int unsigned XTAL_MIN_RESET  = 1000000;
  localparam int unsigned XTAL_MAX_RESET  = 25000000;
  localparam int unsigned DIV_W           = 32;

  localparam logic CFG_XTAL_MIN = 1'b0;
  localparam logic CFG_XTAL_MAX = 1'b1;

  typedef struct packed {
    logic [25:0] crystal_hz;
    logic [19:0] wanted_baud;
    logic [31:0] max_ppm;
  } in_word_t;

  typedef struct packed {
    logic        config_ok;
    logic [5:0]  prescaler_code;
    logic [2:0]  prop_seg_code;
    logic [2:0]  phase1_code;
    logic [2:0]  phase2_code;
    logic [1:0]  jump_width_code;
    logic        triple_sample;
    logic [9:0]  sample_point_permille;
    logic [31:0] ppm_error;
  } out_word_t;

  typedef enum logic [4:0] {
    OP_NONE, OP_LOAD, OP_DIV_BRP, OP_SET_BRP, OP_DIV_A, OP_UPD_A, OP_DIV_B, OP_UPD_B,
    OP_NEXT_TQ, OP_SEG, OP_DIV_SP, OP_SP1, OP_SP2, OP_SP3, OP_DIV_ACT, OP_SET_ACT,
    OP_SET_TEN, OP_DIV_PPM, OP_SET_PPM, OP_MUL_TEN, OP_OUT, OP_OUT_ZERO
  } dp_op_t;

  typedef struct packed {
    logic reject;
    logic brp_in_range;
    logic brp_nz;
    logic brp_lt_max;
    logic tq_is_min;
    logic adj_big;
    logic scale_nz;
    logic out_free;
  } dp_status_t;

  typedef struct packed {
    logic             start;
    logic [DIV_W-1:0] dividend;
    logic [DIV_W-1:0] divisor;
  } div_req_t;

  // floor(2*tq/7) for the phase-2 split
  function automatic logic [2:0] twice_div7(input logic [4:0] tq);
    logic [5:0] t;
    t = {tq, 1'b0};
    if (t >= 6'd49)      twice_div7 = 3'd7;
    else if (t >= 6'd42) twice_div7 = 3'd6;
    else if (t >= 6'd35) twice_div7 = 3'd5;
    else if (t >= 6'd28) twice_div7 = 3'd4;
    else if (t >= 6'd21) twice_div7 = 3'd3;
    else if (t >= 6'd14) twice_div7 = 3'd2;
    else if (t >= 6'd7)  twice_div7 = 3'd1;
    else                 twice_div7 = 3'd0;
  endfunction

endpackage

FILE: rtl/cbts_div.sv
module cbts_div
  import cbts_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  div_req_t         req,
  output logic             busy,
  output logic             done,
  output logic [DIV_W-1:0] quot
);

  logic [DIV_W:0]           rem_r, rem_nxt, rem_sh;
  logic [DIV_W-1:0]         quo_r, quo_nxt, dvs_r, dvs_nxt;
  logic [$clog2(DIV_W):0]   cnt_r, cnt_nxt;
  logic                     busy_r, busy_nxt, done_r, done_nxt;

  always_comb begin
    rem_nxt  = rem_r;
    quo_nxt  = quo_r;
    dvs_nxt  = dvs_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    rem_sh   = {rem_r[DIV_W-1:0], quo_r[DIV_W-1]};
    if (req.start) begin
      rem_nxt  = '0;
      quo_nxt  = req.dividend;
      dvs_nxt  = req.divisor;
      cnt_nxt  = ($clog2(DIV_W)+1)'(DIV_W);
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      if (rem_sh >= {1'b0, dvs_r}) begin
        rem_nxt = rem_sh - {1'b0, dvs_r};
        quo_nxt = {quo_r[DIV_W-2:0], 1'b1};
      end else begin
        rem_nxt = rem_sh;
        quo_nxt = {quo_r[DIV_W-2:0], 1'b0};
      end
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == 1) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    rem_r <= rem_nxt;
    quo_r <= quo_nxt;
    dvs_r <= dvs_nxt;
    cnt_r <= cnt_nxt;
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
  end

  assign busy = busy_r;
  assign done = done_r;
  assign quot = quo_r;

endmodule

FILE: rtl/cbts_dp.sv
module cbts_dp
  import cbts_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             cfg_we,
  input  logic             cfg_index,
  input  logic [25:0]      cfg_data,
  input  in_word_t         in_word,
  input  dp_op_t           op,
  output dp_status_t       status,
  output div_req_t         div_req,
  input  logic [DIV_W-1:0] div_quot,
  output logic             out_valid,
  input  logic             out_ready,
  output out_word_t        out_word
);

  logic [25:0] xmin_r, xmax_r;
  logic [25:0] xtal_r;
  logic [24:0] clk_r;
  logic [19:0] want_r;
  logic [31:0] maxppm_r;
  logic [4:0]  tq_r, btq_r;
  logic [31:0] brp_r, berr_r, adj_r, ppm_r;
  logic [6:0]  bbrp_r;
  logic [4:0]  c2_r, c1_r, cp_r;
  logic [9:0]  sp_r;
  logic [3:0]  k_r;
  logic        ovalid_r;
  out_word_t   oword_r;

  logic [31:0] err_a, err_b, actual_abs;
  logic [6:0]  brp7, brp7p;
  logic [4:0]  p2, rest, p1, c2p1;
  logic [35:0] ppm_x10;
  logic [32:0] ppm_prod;
  logic [63:0] adj_x;
  logic [1:0]  sjw;

  assign brp7       = brp_r[6:0];
  assign brp7p      = brp7 + 7'd1;
  assign err_a      = div_quot - 32'(want_r);
  assign err_b      = 32'(want_r) - div_quot;
  assign actual_abs = (div_quot > 32'(want_r)) ? err_a : err_b;
  assign p2         = 5'd1 + 5'(twice_div7(btq_r));
  assign rest       = btq_r - p2 - 5'd1;
  assign p1         = {1'b0, rest[4:1]};
  assign c2p1       = c2_r + 5'd1;
  assign ppm_x10    = {ppm_r, 3'b000} + {3'b000, ppm_r, 1'b0};
  assign ppm_prod   = 33'(PPM_UNIT) * 33'(adj_r[12:0]);
  // divide by ten: multiply by the rounded-up reciprocal, keep bits above 2^35
  assign adj_x      = 64'(adj_r) * 64'(32'hCCCCCCCD);
  assign sjw        = (c2_r < 5'd4) ? 2'(c2_r - 5'd1) : 2'd3;

  function automatic logic in_range_n();
    in_range_n = (xtal_r < xmin_r) || (xtal_r > xmax_r);
  endfunction

  always_comb begin
    div_req = '{start: 1'b0, dividend: '0, divisor: '0};
    case (op)
      OP_DIV_BRP: div_req = '{1'b1, 32'(clk_r), 32'(want_r * tq_r)};
      OP_DIV_A:   div_req = '{1'b1, 32'(clk_r), 32'(tq_r * brp7)};
      OP_DIV_B:   div_req = '{1'b1, 32'(clk_r), 32'(tq_r * brp7p)};
      OP_DIV_SP:  div_req = '{1'b1, (c2p1 > tq_r) ? 32'd0 :
                                    32'(11'(PERMILLE) * (tq_r - c2p1)), 32'(tq_r)};
      OP_DIV_ACT: div_req = '{1'b1, 32'(clk_r), 32'(btq_r * bbrp_r)};
      OP_DIV_PPM: div_req = '{1'b1, ppm_prod[31:0], 32'(want_r)};
      default:    div_req = '{start: 1'b0, dividend: '0, divisor: '0};
    endcase
  end

  always_comb begin
    status.reject       = (want_r == '0) || (in_range_n());
    status.brp_in_range = brp_r <= 32'(BRP_MAX);
    status.brp_nz       = brp_r != '0;
    status.brp_lt_max   = brp_r < 32'(BRP_MAX);
    status.tq_is_min    = tq_r == 5'(TQ_MIN);
    status.adj_big      = adj_r > 32'(PPM_SCALE_LIMIT);
    status.scale_nz     = k_r != '0;
    status.out_free     = !ovalid_r || out_ready;
  end

  always_ff @(posedge clk) begin
    case (op)
      OP_LOAD: begin
        xtal_r   <= in_word.crystal_hz;
        clk_r    <= in_word.crystal_hz[25:1];
        want_r   <= in_word.wanted_baud;
        maxppm_r <= in_word.max_ppm;
        tq_r     <= 5'(TQ_MAX);
        btq_r    <= 5'(TQ_MAX);
        bbrp_r   <= 7'(BRP_MAX);
        berr_r   <= '1;
      end
      OP_SET_BRP: brp_r <= div_quot;
      OP_UPD_A: begin
        if (err_a < berr_r) begin
          berr_r <= err_a;
          bbrp_r <= brp7;
          btq_r  <= tq_r;
        end
      end
      OP_UPD_B: begin
        if (err_b < berr_r) begin
          berr_r <= err_b;
          bbrp_r <= brp7p;
          btq_r  <= tq_r;
        end
      end
      OP_NEXT_TQ: tq_r <= tq_r - 5'd1;
      OP_SEG: begin
        tq_r <= btq_r;
        c2_r <= p2 - 5'd1;
        c1_r <= p1 - 5'd1;
        cp_r <= rest - p1 - 5'd1;
      end
      OP_SP1: begin
        if (div_quot >= 32'(SP_HIGH)) begin
          c2_r <= c2_r + 5'd1;
          cp_r <= cp_r - 5'd1;
        end
      end
      OP_SP2: begin
        if (div_quot <= 32'(SP_LOW) && c2_r > 5'd1) begin
          c2_r <= c2_r - 5'd1;
          if (c1_r < cp_r) c1_r <= c1_r + 5'd1;
          else cp_r <= cp_r + 5'd1;
        end
      end
      OP_SP3: sp_r <= div_quot[9:0];
      OP_SET_ACT: begin
        adj_r <= actual_abs;
        k_r   <= '0;
      end
      OP_SET_TEN: begin
        adj_r <= 32'(adj_x[63:35]);
        k_r   <= k_r + 4'd1;
      end
      OP_SET_PPM: ppm_r <= div_quot;
      OP_MUL_TEN: begin
        // saturate: once past the top it stays there
        ppm_r <= (ppm_x10[35:32] != '0) ? '1 : ppm_x10[31:0];
        k_r   <= k_r - 4'd1;
      end
      default: ;
    endcase
    if (op == OP_OUT) begin
      oword_r.config_ok             <= ppm_r <= maxppm_r;
      oword_r.prescaler_code        <= 6'(bbrp_r - 7'd1);
      oword_r.prop_seg_code         <= cp_r[2:0];
      oword_r.phase1_code           <= c1_r[2:0];
      oword_r.phase2_code           <= c2_r[2:0];
      oword_r.jump_width_code       <= sjw;
      oword_r.triple_sample         <= (want_r <= 20'(TRIPLE_LIMIT)) && (c2_r >= 5'd1);
      oword_r.sample_point_permille <= sp_r;
      oword_r.ppm_error             <= ppm_r;
    end else if (op == OP_OUT_ZERO) begin
      oword_r <= '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      xmin_r   <= 26'(XTAL_MIN_RESET);
      xmax_r   <= 26'(XTAL_MAX_RESET);
      ovalid_r <= 1'b0;
    end else begin
      if (cfg_we && cfg_index == CFG_XTAL_MIN) xmin_r <= cfg_data;
      if (cfg_we && cfg_index == CFG_XTAL_MAX) xmax_r <= cfg_data;
      if (op == OP_OUT || op == OP_OUT_ZERO) ovalid_r <= 1'b1;
      else if (out_ready) ovalid_r <= 1'b0;
    end
  end

  assign out_valid = ovalid_r;
  assign out_word  = oword_r;

endmodule

FILE: rtl/cbts_ctrl.sv
module cbts_ctrl
  import cbts_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  dp_status_t status,
  input  logic       div_done,
  output dp_op_t     op
);

  typedef enum logic [4:0] {
    S_IDLE, S_CHK, S_BRP, S_LOOP, S_EA, S_BSTART, S_EB, S_NXT, S_NXTD,
    S_SP1S, S_SP1W, S_SP2S, S_SP2W, S_SP3S, S_SP3W, S_ACTS, S_ACTW,
    S_TEN, S_PPMW, S_MUL, S_DONE, S_ZERO
  } state_t;

  state_t state_r, state_nxt;

  always_comb begin
    state_nxt = state_r;
    op        = OP_NONE;
    case (state_r)
      S_IDLE: if (in_valid) begin op = OP_LOAD; state_nxt = S_CHK; end
      S_CHK: begin
        if (status.reject) state_nxt = S_ZERO;
        else begin op = OP_DIV_BRP; state_nxt = S_BRP; end
      end
      S_BRP: if (div_done) begin op = OP_SET_BRP; state_nxt = S_LOOP; end
      S_LOOP: begin
        if (!status.brp_in_range) begin op = OP_SEG; state_nxt = S_SP1S; end
        else if (status.brp_nz) begin op = OP_DIV_A; state_nxt = S_EA; end
        else begin op = OP_DIV_B; state_nxt = S_EB; end
      end
      S_EA: begin
        if (div_done) begin
          op = OP_UPD_A;
          state_nxt = status.brp_lt_max ? S_BSTART : S_NXT;
        end
      end
      S_BSTART: begin op = OP_DIV_B; state_nxt = S_EB; end
      S_EB: if (div_done) begin op = OP_UPD_B; state_nxt = S_NXT; end
      S_NXT: begin
        if (status.tq_is_min) begin op = OP_SEG; state_nxt = S_SP1S; end
        else begin op = OP_NEXT_TQ; state_nxt = S_NXTD; end
      end
      S_NXTD: begin op = OP_DIV_BRP; state_nxt = S_BRP; end
      S_SP1S: begin op = OP_DIV_SP; state_nxt = S_SP1W; end
      S_SP1W: if (div_done) begin op = OP_SP1; state_nxt = S_SP2S; end
      S_SP2S: begin op = OP_DIV_SP; state_nxt = S_SP2W; end
      S_SP2W: if (div_done) begin op = OP_SP2; state_nxt = S_SP3S; end
      S_SP3S: begin op = OP_DIV_SP; state_nxt = S_SP3W; end
      S_SP3W: if (div_done) begin op = OP_SP3; state_nxt = S_ACTS; end
      S_ACTS: begin op = OP_DIV_ACT; state_nxt = S_ACTW; end
      S_ACTW: if (div_done) begin op = OP_SET_ACT; state_nxt = S_TEN; end
      S_TEN: begin
        if (status.adj_big) op = OP_SET_TEN;
        else begin op = OP_DIV_PPM; state_nxt = S_PPMW; end
      end
      S_PPMW: if (div_done) begin op = OP_SET_PPM; state_nxt = S_MUL; end
      S_MUL: begin
        if (status.scale_nz) op = OP_MUL_TEN;
        else state_nxt = S_DONE;
      end
      S_DONE: if (status.out_free) begin op = OP_OUT; state_nxt = S_IDLE; end
      S_ZERO: if (status.out_free) begin op = OP_OUT_ZERO; state_nxt = S_IDLE; end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= S_IDLE;
    else state_r <= state_nxt;
  end

  assign in_ready = state_r == S_IDLE;

endmodule

FILE: rtl/can_bit_timing_search.sv
// CAN bit-timing search. One request (crystal, wanted baud, ppm tolerance) gives one
// result word. A rejected crystal skips the search and gives an all-zero result word;
// otherwise each time-quanta count tried costs up to three divisions on the single
// shared restoring divider, for up to 21 counts, followed by five more divisions for
// the sample point, actual rate and ppm, plus a divide-by-ten step and a multiply-by-ten
// step for each decade of ppm scaling. A new request is taken while the last result
// waits on the output register.
module can_bit_timing_search
  import cbts_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [25:0] cfg_data,
  input  logic        in_valid,
  output logic        in_ready,
  input  in_word_t    in_word,
  output logic        out_valid,
  input  logic        out_ready,
  output out_word_t   out_word
);

  dp_op_t           op;
  dp_status_t       status;
  div_req_t         div_req;
  logic             div_busy, div_done;
  logic [DIV_W-1:0] div_quot;

  cbts_ctrl u_ctrl (
    .clk, .rst_n, .in_valid, .in_ready, .status, .div_done, .op
  );

  cbts_dp u_dp (
    .clk, .rst_n, .cfg_we, .cfg_index, .cfg_data, .in_word, .op, .status,
    .div_req, .div_quot, .out_valid, .out_ready, .out_word
  );

  cbts_div u_div (
    .clk, .rst_n, .req(div_req), .busy(div_busy), .done(div_done), .quot(div_quot)
  );

  a_div_idle: assert property (@(posedge clk) disable iff (!rst_n)
    div_req.start |-> !div_busy) else $error("divider restarted while busy");

  a_one_word: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready) else $error("second word taken during search");

  a_sp_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_word.sample_point_permille <= 10'd1000)
    else $error("sample point out of range");

endmodule
